// ===== hdl/tmv_pkg.sv =====
// Shared types, codes and limits for the tagged message validator.
// Depends on nothing; the check logic, the top level and the testbench refer to it by scoped names.
package tmv_pkg;

	localparam int MAX_MESSAGE_BYTES = 65536;
	localparam int MAX_TAGS          = 65535;

	// data byte count stops here, never beyond what the 17-bit field holds
	localparam logic [16:0] DATA_SAT =
		17'((MAX_MESSAGE_BYTES > 'h1FFFF) ? 'h1FFFF : MAX_MESSAGE_BYTES);
	localparam logic [15:0] INDEX_SAT = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_COUNT  = 2'd0,
		PH_OFFSET = 2'd1,
		PH_TAG    = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE          = 3'd0,
		ERR_TOO_MANY_TAGS = 3'd1,
		ERR_TRUNC_OFFSETS = 3'd2,
		ERR_OFFSET_DECR   = 3'd3,
		ERR_OFFSET_ALIGN  = 3'd4,
		ERR_TRUNC_TAGS    = 3'd5,
		ERR_TAG_ORDER     = 3'd6,
		ERR_OFFSET_PAST   = 3'd7
	} err_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] decl_tags;
		logic [15:0] sect_cnt;
		logic [31:0] prev_offset;
		logic [31:0] prev_tag;
		logic [16:0] data_cnt;
		err_t        err;
	} state_t;

	typedef struct packed {
		logic [1:0]  word_kind;
		logic [15:0] element_index;
		logic        message_done;
		logic        message_ok;
		logic [2:0]  error_code;
		logic [15:0] tag_count;
		logic [16:0] data_bytes;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_COUNT,
		decl_tags:   16'd0,
		sect_cnt:    16'd0,
		prev_offset: 32'd0,
		prev_tag:    32'd0,
		data_cnt:    17'd0,
		err:         ERR_NONE
	};

endpackage

// ===== hdl/tmv_in_if.sv =====
// Input channel of the validator: one message word per beat.
// Depends on nothing.
interface tmv_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic        last_word;

	modport source (output valid, output msg_word, output last_word, input ready);
	modport sink   (input valid, input msg_word, input last_word, output ready);
endinterface

// ===== hdl/tmv_out_if.sv =====
// Output channel of the validator: one result per input beat.
// Depends on nothing.
interface tmv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  word_kind;
	logic [15:0] element_index;
	logic        message_done;
	logic        message_ok;
	logic [2:0]  error_code;
	logic [15:0] tag_count;
	logic [16:0] data_bytes;

	modport source (output valid, output word_kind, output element_index,
		output message_done, output message_ok, output error_code,
		output tag_count, output data_bytes, input ready);
	modport sink   (input valid, input word_kind, input element_index,
		input message_done, input message_ok, input error_code,
		input tag_count, input data_bytes, output ready);
endinterface

// ===== hdl/tmv_check.sv =====
// Per-word check logic: next parser state and the result for one word.
// Depends on tmv_pkg.
module tmv_check (
	input  tmv_pkg::state_t  st,
	input  logic [31:0]      msg_word,
	input  logic             last_word,
	output tmv_pkg::state_t  st_nxt,
	output tmv_pkg::result_t res
);

	logic [16:0]       cnt_inc;
	logic [17:0]       data_sum;
	tmv_pkg::err_t     step_err;
	tmv_pkg::err_t     err_a;
	tmv_pkg::err_t     err_b;
	tmv_pkg::phase_t   phase_nxt;
	tmv_pkg::state_t   st_step;

	assign cnt_inc  = {1'b0, st.sect_cnt} + 17'd1;
	assign data_sum = {1'b0, st.data_cnt} + 18'd4;

	// next phase
	always_comb begin
		phase_nxt = st.phase;
		case (st.phase)
			tmv_pkg::PH_COUNT: begin
				if (msg_word > 32'(tmv_pkg::MAX_TAGS) || msg_word == 32'd0)
					phase_nxt = tmv_pkg::PH_DATA;
				else if (msg_word == 32'd1)
					phase_nxt = tmv_pkg::PH_TAG;
				else
					phase_nxt = tmv_pkg::PH_OFFSET;
			end
			tmv_pkg::PH_OFFSET: begin
				if (cnt_inc >= ({1'b0, st.decl_tags} - 17'd1))
					phase_nxt = tmv_pkg::PH_TAG;
			end
			tmv_pkg::PH_TAG: begin
				if (cnt_inc >= {1'b0, st.decl_tags})
					phase_nxt = tmv_pkg::PH_DATA;
			end
			default: phase_nxt = st.phase;
		endcase
	end

	// datapath registers and the error raised by this word
	always_comb begin
		st_step       = st;
		st_step.phase = phase_nxt;
		step_err      = tmv_pkg::ERR_NONE;
		case (st.phase)
			tmv_pkg::PH_COUNT: begin
				st_step.sect_cnt    = 16'd0;
				st_step.prev_offset = 32'd0;
				st_step.prev_tag    = 32'd0;
				st_step.data_cnt    = 17'd0;
				if (msg_word > 32'(tmv_pkg::MAX_TAGS)) begin
					step_err          = tmv_pkg::ERR_TOO_MANY_TAGS;
					st_step.decl_tags = 16'hFFFF;
				end else begin
					st_step.decl_tags = msg_word[15:0];
				end
			end
			tmv_pkg::PH_OFFSET: begin
				if (msg_word < st.prev_offset)
					step_err = tmv_pkg::ERR_OFFSET_DECR;
				else if (msg_word[1:0] != 2'b00)
					step_err = tmv_pkg::ERR_OFFSET_ALIGN;
				st_step.prev_offset = msg_word;
				st_step.sect_cnt    = (phase_nxt == tmv_pkg::PH_TAG) ? 16'd0 : cnt_inc[15:0];
			end
			tmv_pkg::PH_TAG: begin
				if (st.sect_cnt != 16'd0 && msg_word <= st.prev_tag)
					step_err = tmv_pkg::ERR_TAG_ORDER;
				st_step.prev_tag = msg_word;
				st_step.sect_cnt = (phase_nxt == tmv_pkg::PH_DATA) ? 16'd0 : cnt_inc[15:0];
			end
			default: begin
				if (data_sum > {1'b0, tmv_pkg::DATA_SAT})
					st_step.data_cnt = tmv_pkg::DATA_SAT;
				else
					st_step.data_cnt = data_sum[16:0];
				if (st.sect_cnt != tmv_pkg::INDEX_SAT)
					st_step.sect_cnt = cnt_inc[15:0];
			end
		endcase
	end

	// keep only the first error of the message; on the last word, add the end-of-message checks
	always_comb begin
		err_a = st.err;
		if (err_a == tmv_pkg::ERR_NONE)
			err_a = step_err;
		err_b = err_a;
		if (last_word && err_a == tmv_pkg::ERR_NONE) begin
			if (phase_nxt == tmv_pkg::PH_OFFSET)
				err_b = tmv_pkg::ERR_TRUNC_OFFSETS;
			else if (phase_nxt == tmv_pkg::PH_TAG)
				err_b = tmv_pkg::ERR_TRUNC_TAGS;
			else if (st_step.prev_offset > {15'd0, st_step.data_cnt})
				err_b = tmv_pkg::ERR_OFFSET_PAST;
		end
	end

	always_comb begin
		res.word_kind     = st.phase;
		res.element_index = (st.phase == tmv_pkg::PH_COUNT) ? 16'd0 : st.sect_cnt;
		res.message_done  = last_word;
		res.message_ok    = last_word && (err_b == tmv_pkg::ERR_NONE);
		res.error_code    = err_b;
		res.tag_count     = st_step.decl_tags;
		res.data_bytes    = st_step.data_cnt;
	end

	// return to the reset state once the message has ended
	always_comb begin
		if (last_word) begin
			st_nxt = tmv_pkg::STATE_RESET;
		end else begin
			st_nxt     = st_step;
			st_nxt.err = err_b;
		end
	end

endmodule

// ===== hdl/tagged_message_validator_top.sv =====
// Top level of the tagged message validator: input register, check logic,
// result register. Depends on tmv_pkg, tmv_in_if, tmv_out_if and tmv_check.
//
// Usage: words of a message enter on msg_in, one 32-bit word per beat, with
// last_word high on the final word. Every input beat yields exactly one
// result beat on res_out, in order: the kind of the word, its index within
// its section, the declared tag count, the data byte count so far and the
// sticky error. On the last word message_done is high and message_ok gives
// the verdict; the parser then waits for the next count word.
// A word passes the input register, then the check logic into the result register.
// Throughput is one word per cycle while the receiver does not stall, set by the
// combinational state update between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; msg_in.ready falls only when both are full.
// Reset clears both valid flags and returns the parser to the count word.
module tagged_message_validator_top (
	input  logic        clk,
	input  logic        arst_n,
	tmv_in_if.sink      msg_in,
	tmv_out_if.source   res_out
);

	logic              valid_s1;
	logic [31:0]       word_s1;
	logic              last_s1;
	logic              valid_s2;
	tmv_pkg::result_t  res_s2;
	tmv_pkg::result_t  res_nxt;
	tmv_pkg::state_t   st_q;
	tmv_pkg::state_t   st_nxt;
	logic              advance;

	// result register free, or emptied this cycle
	assign advance      = !valid_s2 || res_out.ready;
	assign msg_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_in.ready) begin
			valid_s1 <= msg_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_in.ready && msg_in.valid) begin
			word_s1 <= msg_in.msg_word;
			last_s1 <= msg_in.last_word;
		end
	end

	tmv_check u_check (
		.st        (st_q),
		.msg_word  (word_s1),
		.last_word (last_s1),
		.st_nxt    (st_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= tmv_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res_nxt;
	end

	assign res_out.valid         = valid_s2;
	assign res_out.word_kind     = res_s2.word_kind;
	assign res_out.element_index = res_s2.element_index;
	assign res_out.message_done  = res_s2.message_done;
	assign res_out.message_ok    = res_s2.message_ok;
	assign res_out.error_code    = res_s2.error_code;
	assign res_out.tag_count     = res_s2.tag_count;
	assign res_out.data_bytes    = res_s2.data_bytes;

	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.message_ok |->
			res_s2.message_done && res_s2.error_code == tmv_pkg::ERR_NONE)
		else $error("message_ok with an error or without message_done");

	a_count_index: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.word_kind == tmv_pkg::PH_COUNT |->
			res_s2.element_index == 16'd0 && res_s2.data_bytes == 17'd0)
		else $error("count word with nonzero index or data count");

	a_data_sat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.data_bytes <= tmv_pkg::DATA_SAT)
		else $error("data byte count beyond saturation");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && last_s1 |=> st_q.phase == tmv_pkg::PH_COUNT &&
			st_q.err == tmv_pkg::ERR_NONE)
		else $error("parser not back at count word after last word");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for tagged_message_validator_top: drives message words, predicts every result.
// Depends on tmv_pkg, tmv_in_if, tmv_out_if and the validator top level.
module tb;

	// Predicts one result per accepted word and holds the results still to come.
	class verdict_board;
		tmv_pkg::result_t expected_verdicts[$];
		int unsigned      failures;
		tmv_pkg::phase_t  cur_phase;
		int unsigned      tags_declared;
		int unsigned      pos;
		int unsigned      last_offset;
		int unsigned      last_tag;
		int unsigned      byte_cnt;
		tmv_pkg::err_t    held_err;

		function new();
			failures = 0;
			clear_state();
		endfunction

		function void clear_state();
			cur_phase     = tmv_pkg::PH_COUNT;
			tags_declared = 0;
			pos           = 0;
			last_offset   = 0;
			last_tag      = 0;
			byte_cnt      = 0;
			held_err      = tmv_pkg::ERR_NONE;
		endfunction

		// keep only the first error of the message
		function void flag_error(tmv_pkg::err_t code);
			if (held_err == tmv_pkg::ERR_NONE)
				held_err = code;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		function void note_word(logic [31:0] w, logic is_last);
			tmv_pkg::result_t r;
			int unsigned      idx;
			r.word_kind = cur_phase;
			idx = pos;
			case (cur_phase)
				tmv_pkg::PH_COUNT: begin
					idx         = 0;
					pos         = 0;
					last_offset = 0;
					last_tag    = 0;
					byte_cnt    = 0;
					if (w > tmv_pkg::MAX_TAGS) begin
						flag_error(tmv_pkg::ERR_TOO_MANY_TAGS);
						tags_declared = 16'hFFFF;
						cur_phase     = tmv_pkg::PH_DATA;
					end else begin
						tags_declared = w;
						if (w >= 2)
							cur_phase = tmv_pkg::PH_OFFSET;
						else if (w == 1)
							cur_phase = tmv_pkg::PH_TAG;
						else
							cur_phase = tmv_pkg::PH_DATA;
					end
				end
				tmv_pkg::PH_OFFSET: begin
					if (w < last_offset)
						flag_error(tmv_pkg::ERR_OFFSET_DECR);
					else if (w[1:0] != 2'b00)
						flag_error(tmv_pkg::ERR_OFFSET_ALIGN);
					last_offset = w;
					pos++;
					if (pos >= tags_declared - 1) begin
						cur_phase = tmv_pkg::PH_TAG;
						pos       = 0;
					end
				end
				tmv_pkg::PH_TAG: begin
					if (idx > 0 && w <= last_tag)
						flag_error(tmv_pkg::ERR_TAG_ORDER);
					last_tag = w;
					pos++;
					if (pos >= tags_declared) begin
						cur_phase = tmv_pkg::PH_DATA;
						pos       = 0;
					end
				end
				default: begin
					byte_cnt += 4;
					if (byte_cnt > tmv_pkg::DATA_SAT)
						byte_cnt = tmv_pkg::DATA_SAT;
					if (pos < tmv_pkg::INDEX_SAT)
						pos++;
				end
			endcase
			if (is_last) begin
				if (cur_phase == tmv_pkg::PH_OFFSET)
					flag_error(tmv_pkg::ERR_TRUNC_OFFSETS);
				else if (cur_phase == tmv_pkg::PH_TAG)
					flag_error(tmv_pkg::ERR_TRUNC_TAGS);
				else if (held_err == tmv_pkg::ERR_NONE && last_offset > byte_cnt)
					flag_error(tmv_pkg::ERR_OFFSET_PAST);
			end
			r.element_index = idx[15:0];
			r.message_done  = is_last;
			r.message_ok    = is_last && held_err == tmv_pkg::ERR_NONE;
			r.error_code    = held_err;
			r.tag_count     = tags_declared[15:0];
			r.data_bytes    = byte_cnt[16:0];
			expected_verdicts.push_back(r);
			if (is_last)
				clear_state();
		endfunction

		function void check_verdict(tmv_pkg::result_t got);
			tmv_pkg::result_t want;
			if (expected_verdicts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%t: result beat with nothing expected: kind %0d index %0d",
						$time, got.word_kind, got.element_index);
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.word_kind !== want.word_kind || got.element_index !== want.element_index ||
				got.message_done !== want.message_done || got.message_ok !== want.message_ok ||
				got.error_code !== want.error_code || got.tag_count !== want.tag_count ||
				got.data_bytes !== want.data_bytes) begin
				failures++;
				if (failures <= 10) begin
					$write("%t: mismatch (exp/got) kind %0d/%0d index %0d/%0d done %0d/%0d ",
						$time, want.word_kind, got.word_kind, want.element_index,
						got.element_index, want.message_done, got.message_done);
					$display("ok %0d/%0d err %0d/%0d tags %0d/%0d bytes %0d/%0d",
						want.message_ok, got.message_ok, want.error_code, got.error_code,
						want.tag_count, got.tag_count, want.data_bytes, got.data_bytes);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tmv_in_if  word_if ();
	tmv_out_if verdict_if ();

	tagged_message_validator_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg_in  (word_if),
		.res_out (verdict_if)
	);

	verdict_board board = new();
	int unsigned  burst_left;
	int unsigned  sent_words;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		tmv_pkg::result_t got;
		if (word_if.valid === 1'b1 && word_if.ready === 1'b1)
			board.note_word(word_if.msg_word, word_if.last_word);
		if (verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1) begin
			got = {verdict_if.word_kind, verdict_if.element_index, verdict_if.message_done,
				verdict_if.message_ok, verdict_if.error_code, verdict_if.tag_count,
				verdict_if.data_bytes};
			board.check_verdict(got);
		end
	end

	// receiver: switch between always ready, random stall patterns and heavy stalling
	initial begin
		int unsigned pattern;
		int unsigned left;
		verdict_if.ready <= 1'b0;
		pattern = 0;
		left    = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				left = $urandom_range(16, 200);
				case ($urandom_range(0, 3))
					0:       pattern = '1;
					1:       pattern = $urandom | 1;
					2:       pattern = $urandom | $urandom | 1;
					default: pattern = ($urandom & $urandom) | 1;
				endcase
			end
			verdict_if.ready <= pattern[0];
			pattern = {pattern[0], pattern[31:1]};
			left--;
		end
	end

	// send one beat; sender runs in bursts with random gaps between them
	task automatic send_word(input logic [31:0] w, input logic is_last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				word_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		word_if.valid     <= 1'b1;
		word_if.msg_word  <= w;
		word_if.last_word <= is_last;
		@(posedge clk);
		while (word_if.ready !== 1'b1)
			@(posedge clk);
		burst_left--;
		sent_words++;
	endtask

	task automatic send_short(input int len, input logic [31:0] w0, input logic [31:0] w1 = 0,
		input logic [31:0] w2 = 0, input logic [31:0] w3 = 0);
		logic [31:0] ws[4];
		ws = '{w0, w1, w2, w3};
		for (int i = 0; i < len; i++)
			send_word(ws[i], i == len - 1);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic drain();
		word_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed messages with random content, some flawed, cut short or noise
	task automatic random_message();
		logic [31:0] words[$];
		int unsigned n_tags;
		int unsigned n_data;
		int unsigned pick;
		int unsigned keep;
		logic [31:0] off;
		logic [31:0] tag;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) words.push_back($urandom);
		end else begin
			if (pick < 12)
				n_tags = $urandom_range(tmv_pkg::MAX_TAGS + 1, 32'hFFFF_FFFF);
			else if (pick < 22)
				n_tags = $urandom_range(0, 1);
			else if (pick < 30)
				n_tags = $urandom_range(9, 40);
			else
				n_tags = $urandom_range(2, 8);
			words.push_back(n_tags);
			n_data = $urandom_range(0, 14);
			if (n_tags <= tmv_pkg::MAX_TAGS) begin
				off = 0;
				for (int i = 1; i < n_tags; i++) begin
					off += 4 * $urandom_range(0, 2);
					case ($urandom_range(0, 39))
						0:       words.push_back(off | $urandom_range(1, 3));
						1:       words.push_back(off - $urandom_range(1, 8));
						2:       words.push_back($urandom & ~32'd3);
						default: words.push_back(off);
					endcase
				end
				tag = $urandom_range(0, 32'hF000_0000);
				for (int i = 0; i < n_tags; i++) begin
					tag += $urandom_range(1, 1 << 20);
					// repeat the previous tag to break strict order
					if (i > 0 && $urandom_range(0, 49) == 0)
						words.push_back(words[words.size() - 1]);
					else
						words.push_back(tag);
				end
			end
			repeat (n_data) words.push_back($urandom);
			if ($urandom_range(0, 9) == 0) begin
				keep = $urandom_range(1, words.size());
				while (words.size() > keep)
					void'(words.pop_back());
			end
		end
		for (int i = 0; i < words.size(); i++)
			send_word(words[i], i == words.size() - 1);
	endtask

	initial begin
		int unsigned rand_start;
		int unsigned guard;
		bit          paused;
		arst_n            <= 1'b0;
		word_if.valid     <= 1'b0;
		word_if.msg_word  <= '0;
		word_if.last_word <= 1'b0;
		burst_left = 0;
		sent_words = 0;
		paused     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty message, then too many tags at the boundary
		send_short(1, 32'd0);
		send_short(2, 32'h0001_0000, 32'hFFFF_FFFF);
		// maximum count ending inside the offsets
		send_short(2, 32'(tmv_pkg::MAX_TAGS), 32'd4);
		// single tag, no offsets, no data
		send_short(2, 32'd1, 32'hFFFF_FFFF);
		send_short(4, 32'd3, 32'd8, 32'd4, 32'd5);
		send_short(4, 32'd2, 32'd6, 32'd9, 32'd9);
		// ends inside the tags
		send_short(3, 32'd2, 32'd0, 32'd7);
		send_short(4, 32'd2, 32'd0, 32'd3, 32'd1);
		// clean layout, but the offset points past the data
		send_short(4, 32'd2, 32'd4, 32'd1, 32'd2);
		drain();

		rand_start = sent_words;
		while (sent_words - rand_start < 925) begin
			random_message();
			if (!paused && sent_words - rand_start >= 460) begin
				drain();
				paused = 1;
			end
		end
		word_if.valid <= 1'b0;

		guard = 0;
		while (board.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (board.pending() != 0)
			$display("%0d expected results never arrived", board.pending());
		if (board.failures == 0 && board.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/tmv_pkg.sv
hdl/tmv_in_if.sv
hdl/tmv_out_if.sv
hdl/tmv_check.sv
hdl/tagged_message_validator_top.sv
test/tb.sv
